[design/glt_pkg.sv]
// ----------------------------------------------------------------------------
// glt_pkg
// Shared types, constants and GF(4) helpers for the hyperplane load tracker.
// ----------------------------------------------------------------------------
package glt_pkg;

  localparam int DIMENSION    = 5;
  localparam int POINT_COUNT  = 1024;
  localparam int SEED_COLUMNS = 9;
  localparam int MAX_DEPTH    = 16;

  localparam int PT_W       = $clog2(POINT_COUNT);
  localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
  localparam int LVL_W      = $clog2(MAX_DEPTH);
  localparam int LANES      = 32;
  localparam int FULL_WORDS = POINT_COUNT / LANES;
  localparam int FW_W       = $clog2(FULL_WORDS);
  localparam int LANE_W     = $clog2(LANES);
  localparam int SUB_W      = FW_W + 1;
  localparam int LOAD_W     = 4;
  localparam int HYP_W      = 8 * 4;
  localparam int BC_W       = 5;
  localparam int PNT_W      = BC_W + 1;
  localparam int CFG_W      = 40;
  localparam int SUM_W      = LOAD_W + 2;

  localparam logic [LOAD_W-1:0] LIMIT_RESET = 4'd9;

  // item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PLACE = 2'd1;
  localparam logic [1:0] KIND_UNDO  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // configuration register indexes
  localparam logic REG_SEED_PARITY = 1'b0;
  localparam logic REG_LOAD_LIMIT  = 1'b1;

  // datapath phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CLEAR   = 3'd1;
  localparam logic [2:0] PH_LOOK    = 3'd2;
  localparam logic [2:0] PH_CHECK   = 3'd3;
  localparam logic [2:0] PH_UPDATE  = 3'd4;
  localparam logic [2:0] PH_BLOCK   = 3'd5;
  localparam logic [2:0] PH_UNLEVEL = 3'd6;
  localparam logic [2:0] PH_UNLOAD  = 3'd7;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PT_W-1:0] point;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               point_free;
    logic [PT_W-1:0]    newly_blocked;
    logic [DEPTH_W-1:0] depth_now;
  } out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       restart;
    logic       accept;
    logic [1:0] kind;
    logic       pop;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic               over;
    logic               inpath;
    logic               bc_zero;
    logic               depth_full;
    logic               depth_empty;
    logic [PT_W-1:0]    blocked;
    logic [DEPTH_W-1:0] depth;
  } sts_t;

  function automatic logic [1:0] gf4_mul(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    case ({a, b})
      4'b0101: r = 2'd1;
      4'b0110: r = 2'd2;
      4'b0111: r = 2'd3;
      4'b1001: r = 2'd2;
      4'b1010: r = 2'd3;
      4'b1011: r = 2'd1;
      4'b1101: r = 2'd3;
      4'b1110: r = 2'd1;
      4'b1111: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dot4(input logic [PT_W-1:0] m, input logic [PT_W-1:0] x);
    logic [1:0] s;
    s = 2'd0;
    for (int d = 0; d < DIMENSION; d++) begin
      s = s ^ gf4_mul(m[2*d +: 2], x[2*d +: 2]);
    end
    return s;
  endfunction

  function automatic logic [PT_W-1:0] seed_column(input int j, input logic [CFG_W-1:0] par);
    logic [PT_W-1:0] v;
    v = '0;
    if (j < DIMENSION) begin
      v[2*j] = 1'b1;
    end else if (j - DIMENSION < 4) begin
      for (int i = 0; i < DIMENSION; i++) begin
        v[2*i +: 2] = par[2*(4*i + j - DIMENSION) +: 2];
      end
    end
    return v;
  endfunction

  // seed loads of all four cosets of one direction, load fields zero
  function automatic logic [HYP_W-1:0] seed_word(input logic [PT_W-1:0] m,
                                                 input logic [CFG_W-1:0] par);
    logic [HYP_W-1:0]  w;
    logic [LOAD_W-1:0] c;
    logic [1:0]        a [SEED_COLUMNS];
    w = '0;
    for (int j = 0; j < SEED_COLUMNS; j++) begin
      a[j] = dot4(m, seed_column(j, par));
    end
    for (int k = 0; k < 4; k++) begin
      c = '0;
      for (int j = 0; j < SEED_COLUMNS; j++) begin
        c = c + LOAD_W'(a[j] == 2'(k));
      end
      w[8*k + 4 +: 4] = c;
    end
    return w;
  endfunction

endpackage

[design/glt_ram.sv]
// ----------------------------------------------------------------------------
// glt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/glt_datapath.sv]
// ----------------------------------------------------------------------------
// glt_datapath
// Hyperplane, point, level and full-direction stores with the walks over them.
// ----------------------------------------------------------------------------
module glt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  glt_pkg::cmd_t               cmd,
  input  logic [glt_pkg::PT_W-1:0]    item_point,
  input  logic                        cfg_wen,
  input  logic                        cfg_index,
  input  logic [glt_pkg::CFG_W-1:0]   cfg_data,
  output glt_pkg::sts_t               sts
);
  import glt_pkg::*;

  logic [CFG_W-1:0]   seed_parity;
  logic [CFG_W-1:0]   parity_snap;
  logic [LOAD_W-1:0]  load_limit;
  logic [PT_W-1:0]    cur_pt;
  logic [DEPTH_W-1:0] depth;
  logic [PT_W-1:0]    path_point [MAX_DEPTH];
  logic [PT_W:0]      idx;
  logic               rd_v;
  logic [PT_W-1:0]    rd_idx;
  logic [SUB_W-1:0]   sub;
  logic               over_q;
  logic               hit_q;
  logic [PT_W-1:0]    blk_cnt;
  logic [LANES-1:0]   fbuf;

  logic               hyp_we;
  logic [PT_W-1:0]    hyp_waddr;
  logic [HYP_W-1:0]   hyp_wdata, hyp_rdata;
  logic               pnt_we;
  logic [PT_W-1:0]    pnt_waddr, pnt_raddr;
  logic [PNT_W-1:0]   pnt_wdata, pnt_rdata;
  logic               lvl_we;
  logic [MAX_DEPTH-1:0] lvl_wdata, lvl_rdata;
  logic               full_we;
  logic [LANES-1:0]   full_wdata, full_rdata;

  logic               issue;
  logic [LVL_W-1:0]   lvl_sel;
  logic [DEPTH_W-1:0] depth_dec;
  logic [1:0]         coset;
  logic [LOAD_W-1:0]  ld, sd;
  logic [SUM_W-1:0]   sum;
  logic               ovf, full_bit;
  logic [PT_W-1:0]    diff;
  logic [FW_W-1:0]    word_sel;
  logic               any_hit, blocked;
  logic               sub_last;
  logic [BC_W-1:0]    bc;

  assign issue     = !idx[PT_W];
  assign lvl_sel   = depth[LVL_W-1:0];
  assign depth_dec = depth - DEPTH_W'(1);
  assign sub_last  = (sub == SUB_W'(FULL_WORDS));
  assign bc        = pnt_rdata[PNT_W-1:1];

  // per-direction load check and update
  always_comb begin
    coset    = dot4(rd_idx, cur_pt);
    ld       = hyp_rdata[{coset, 3'b000} +: LOAD_W];
    sd       = hyp_rdata[{coset, 3'b100} +: LOAD_W];
    sum      = SUM_W'(ld) + SUM_W'(1) + SUM_W'(sd);
    ovf      = (sum > SUM_W'(load_limit)) && (rd_idx != '0);
    full_bit = (sum == SUM_W'(load_limit)) && (rd_idx != '0);
  end

  // 32 directions per cycle tested against the point being blocked
  always_comb begin
    diff     = idx[PT_W-1:0] ^ cur_pt;
    word_sel = FW_W'(sub - SUB_W'(1));
    any_hit  = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      if (full_rdata[k] && dot4({word_sel, LANE_W'(k)}, diff) == 2'd0) begin
        any_hit = 1'b1;
      end
    end
    blocked = (hit_q || any_hit) && (idx[PT_W-1:0] != cur_pt) && !pnt_rdata[0];
  end

  // store write ports
  always_comb begin
    hyp_we     = 1'b0;
    hyp_waddr  = rd_idx;
    hyp_wdata  = hyp_rdata;
    pnt_we     = 1'b0;
    pnt_waddr  = rd_idx;
    pnt_wdata  = pnt_rdata;
    pnt_raddr  = idx[PT_W-1:0];
    lvl_we     = 1'b0;
    lvl_wdata  = lvl_rdata;
    full_we    = 1'b0;
    full_wdata = fbuf;
    case (cmd.phase)
      PH_CLEAR: begin
        hyp_we    = issue;
        hyp_waddr = idx[PT_W-1:0];
        hyp_wdata = seed_word(idx[PT_W-1:0], parity_snap);
        pnt_we    = issue;
        pnt_waddr = idx[PT_W-1:0];
        pnt_wdata = '0;
      end
      PH_LOOK: begin
        pnt_raddr = cur_pt;
      end
      PH_UPDATE: begin
        hyp_we = rd_v && (rd_idx != '0);
        hyp_wdata[{coset, 3'b000} +: LOAD_W] = ld + LOAD_W'(1);
        full_we = rd_v && (&rd_idx[LANE_W-1:0]);
        full_wdata[LANES-1] = full_bit;
      end
      PH_BLOCK: begin
        pnt_we    = issue && sub_last;
        pnt_waddr = idx[PT_W-1:0];
        pnt_wdata = {bc + BC_W'(blocked),
                     (idx[PT_W-1:0] == cur_pt) ? 1'b1 : pnt_rdata[0]};
        lvl_we    = issue && sub_last;
        lvl_wdata[lvl_sel] = blocked;
      end
      PH_UNLEVEL: begin
        pnt_we = rd_v;
        pnt_wdata = {(lvl_rdata[lvl_sel] && bc != '0) ? bc - BC_W'(1) : bc,
                     (rd_idx == cur_pt) ? 1'b0 : pnt_rdata[0]};
      end
      PH_UNLOAD: begin
        hyp_we = rd_v && (rd_idx != '0) && (ld != '0);
        hyp_wdata[{coset, 3'b000} +: LOAD_W] = ld - LOAD_W'(1);
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_parity <= '0;
      load_limit  <= LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SEED_PARITY: seed_parity <= cfg_data;
        REG_LOAD_LIMIT:  load_limit  <= cfg_data[LOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stack and item state
  always_ff @(posedge clk) begin
    if (rst) begin
      depth       <= '0;
      parity_snap <= '0;
      blk_cnt     <= '0;
    end else begin
      if (cmd.accept) begin
        blk_cnt <= '0;
        if (cmd.kind == KIND_UNDO) begin
          cur_pt <= path_point[depth_dec[LVL_W-1:0]];
        end else begin
          cur_pt <= item_point;
        end
        if (cmd.kind == KIND_CLEAR) begin
          depth       <= '0;
          parity_snap <= seed_parity;
        end
      end
      if (cmd.pop) begin
        depth <= depth_dec;
      end
      if (cmd.push) begin
        path_point[lvl_sel] <= cur_pt;
        depth <= depth + DEPTH_W'(1);
      end
      if (cmd.phase == PH_BLOCK && issue && sub_last && blocked) begin
        blk_cnt <= blk_cnt + PT_W'(1);
      end
    end
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      idx    <= '0;
      rd_v   <= 1'b0;
      sub    <= '0;
      over_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      case (cmd.phase)
        PH_CLEAR: begin
          rd_v <= 1'b0;
          if (issue) idx <= idx + (PT_W+1)'(1);
        end
        PH_LOOK: begin
          rd_v <= (idx == '0);
          if (idx == '0) begin
            idx <= (PT_W+1)'(1);
          end
        end
        PH_CHECK, PH_UPDATE, PH_UNLEVEL, PH_UNLOAD: begin
          rd_v <= issue;
          if (issue) begin
            idx    <= idx + (PT_W+1)'(1);
            rd_idx <= idx[PT_W-1:0];
          end
          if (cmd.phase == PH_CHECK && rd_v && ovf) over_q <= 1'b1;
          if (cmd.phase == PH_UPDATE && rd_v) fbuf[rd_idx[LANE_W-1:0]] <= full_bit;
        end
        PH_BLOCK: begin
          rd_v <= 1'b0;
          if (issue) begin
            if (sub_last) begin
              sub   <= '0;
              hit_q <= 1'b0;
              idx   <= idx + (PT_W+1)'(1);
            end else begin
              sub <= sub + SUB_W'(1);
              if (sub != '0) hit_q <= hit_q || any_hit;
            end
          end
        end
        default: begin
          rd_v <= 1'b0;
        end
      endcase
    end
  end

  glt_ram #(.WIDTH(HYP_W), .DEPTH(POINT_COUNT)) u_hyp (
    .clk(clk), .we(hyp_we), .waddr(hyp_waddr), .wdata(hyp_wdata),
    .raddr(idx[PT_W-1:0]), .rdata(hyp_rdata)
  );

  glt_ram #(.WIDTH(PNT_W), .DEPTH(POINT_COUNT)) u_pnt (
    .clk(clk), .we(pnt_we), .waddr(pnt_waddr), .wdata(pnt_wdata),
    .raddr(pnt_raddr), .rdata(pnt_rdata)
  );

  glt_ram #(.WIDTH(MAX_DEPTH), .DEPTH(POINT_COUNT)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(idx[PT_W-1:0]), .wdata(lvl_wdata),
    .raddr(idx[PT_W-1:0]), .rdata(lvl_rdata)
  );

  glt_ram #(.WIDTH(LANES), .DEPTH(FULL_WORDS)) u_full (
    .clk(clk), .we(full_we), .waddr(rd_idx[PT_W-1:LANE_W]), .wdata(full_wdata),
    .raddr(sub[FW_W-1:0]), .rdata(full_rdata)
  );

  always_comb begin
    case (cmd.phase)
      PH_CLEAR:  sts.done = issue && (&idx[PT_W-1:0]);
      PH_LOOK:   sts.done = rd_v;
      PH_BLOCK:  sts.done = issue && sub_last && (&idx[PT_W-1:0]);
      PH_CHECK, PH_UPDATE, PH_UNLEVEL, PH_UNLOAD: sts.done = rd_v && (&rd_idx);
      default:   sts.done = 1'b0;
    endcase
    sts.over        = over_q || (rd_v && ovf);
    sts.inpath      = pnt_rdata[0];
    sts.bc_zero     = (bc == '0);
    sts.depth_full  = (depth >= DEPTH_W'(MAX_DEPTH));
    sts.depth_empty = (depth == '0);
    sts.blocked     = blk_cnt;
    sts.depth       = depth;
  end

endmodule

[design/glt_ctrl.sv]
// ----------------------------------------------------------------------------
// glt_ctrl
// Sequencer for clear, place, undo and query items; owns the result register.
// ----------------------------------------------------------------------------
module glt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic [1:0]      item_kind,
  output logic            result_valid,
  input  logic            result_stall,
  output glt_pkg::out_t   result,
  output glt_pkg::cmd_t   cmd,
  input  glt_pkg::sts_t   sts
);
  import glt_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LOOK    = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_UPDATE  = 4'd4;
  localparam logic [3:0] S_BLOCK   = 4'd5;
  localparam logic [3:0] S_UNLEVEL = 4'd6;
  localparam logic [3:0] S_UNLOAD  = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state, state_next;
  logic       report, report_next;
  logic [1:0] kind, kind_next;
  logic [1:0] res_status, res_status_next;
  logic       res_free, res_free_next;
  logic       load_out;

  assign item_stall = (state != S_IDLE);
  assign load_out   = (state == S_FINISH) && !(result_valid && result_stall);

  always_comb begin
    state_next      = state;
    report_next     = report;
    kind_next       = kind;
    res_status_next = res_status;
    res_free_next   = res_free;
    cmd             = '0;
    cmd.kind        = item_kind;
    case (state)
      S_CLEAR: begin
        cmd.phase = PH_CLEAR;
        if (sts.done) state_next = report ? S_FINISH : S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept      = 1'b1;
          cmd.restart     = 1'b1;
          report_next     = 1'b1;
          kind_next       = item_kind;
          res_status_next = ST_DONE;
          res_free_next   = 1'b0;
          case (item_kind)
            KIND_CLEAR: state_next = S_CLEAR;
            KIND_PLACE: begin
              if (sts.depth_full) begin
                res_status_next = ST_FULL;
                state_next      = S_FINISH;
              end else begin
                state_next = S_LOOK;
              end
            end
            KIND_UNDO: begin
              if (sts.depth_empty) begin
                res_status_next = ST_EMPTY;
                state_next      = S_FINISH;
              end else begin
                cmd.pop    = 1'b1;
                state_next = S_UNLEVEL;
              end
            end
            default: state_next = S_LOOK;
          endcase
        end
      end
      S_LOOK: begin
        cmd.phase = PH_LOOK;
        if (sts.done) begin
          if (kind == KIND_QUERY) begin
            res_free_next = !sts.inpath && sts.bc_zero;
            state_next    = S_FINISH;
          end else if (sts.inpath) begin
            res_status_next = ST_REJECT;
            state_next      = S_FINISH;
          end else begin
            cmd.restart = 1'b1;
            state_next  = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.phase = PH_CHECK;
        if (sts.done) begin
          if (sts.over) begin
            res_status_next = ST_REJECT;
            state_next      = S_FINISH;
          end else begin
            cmd.restart = 1'b1;
            state_next  = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        cmd.phase = PH_UPDATE;
        if (sts.done) begin
          cmd.restart = 1'b1;
          state_next  = S_BLOCK;
        end
      end
      S_BLOCK: begin
        cmd.phase = PH_BLOCK;
        if (sts.done) begin
          cmd.push   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_UNLEVEL: begin
        cmd.phase = PH_UNLEVEL;
        if (sts.done) begin
          cmd.restart = 1'b1;
          state_next  = S_UNLOAD;
        end
      end
      S_UNLOAD: begin
        cmd.phase = PH_UNLOAD;
        if (sts.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      report       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      report       <= report_next;
      result_valid <= load_out || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    res_status <= res_status_next;
    res_free   <= res_free_next;
    if (load_out) begin
      result.status        <= res_status;
      result.point_free    <= res_free;
      result.newly_blocked <= sts.blocked;
      result.depth_now     <= sts.depth;
    end
  end

endmodule

[design/gf4_hyperplane_load_tracker.sv]
// ----------------------------------------------------------------------------
// gf4_hyperplane_load_tracker
// Load tracker for all affine hyperplanes of AG(5,4) with a place/undo stack.
// An accepted place item walks all 1024 directions to check the loads, walks
// them again to update them, and then walks every point for the blocking walk,
// 32 full directions tested per cycle from the full-direction RAM.
// One item at a time; a finished result waits in the output register.
// Reset runs a clearing pass over the stores; no item is taken
// during it.
// ----------------------------------------------------------------------------
module gf4_hyperplane_load_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  glt_pkg::in_t               item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output glt_pkg::out_t              result,
  input  logic                       cfg_wen,
  input  logic                       cfg_index,
  input  logic [glt_pkg::CFG_W-1:0]  cfg_data
);
  import glt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  glt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item_kind(item.kind),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cmd(cmd), .sts(sts)
  );

  glt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .item_point(item.point),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data), .sts(sts)
  );

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.depth_now <= DEPTH_W'(MAX_DEPTH))
    else $error("depth beyond stack size");

  a_no_block_on_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_DONE) |-> result.newly_blocked == '0)
    else $error("blocked count on a failed item");

  a_free_only_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.point_free) |-> result.status == ST_DONE)
    else $error("free flag on a failed item");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (sts.depth == $past(sts.depth) || sts.depth == '0 ||
                     sts.depth == $past(sts.depth) + DEPTH_W'(1) ||
                     sts.depth == $past(sts.depth) - DEPTH_W'(1)))
    else $error("stack depth jumped");

endmodule

[tb/sv/gf4_hyperplane_load_tracker_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf4_hyperplane_load_tracker_chk
// Watches the item, result and register ports of the hyperplane load tracker,
// predicts every result from a shadow copy of the loads and the undo stack,
// and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gf4_hyperplane_load_tracker_chk (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  glt_pkg::in_t               item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  glt_pkg::out_t              result,
  input  logic                       cfg_wen,
  input  logic                       cfg_index,
  input  logic [glt_pkg::CFG_W-1:0]  cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         depth
);
  import glt_pkg::*;

  logic [1:0] gmul [4][4] = '{'{0, 0, 0, 0}, '{0, 1, 2, 3}, '{0, 2, 3, 1}, '{0, 3, 1, 2}};

  logic [CFG_W-1:0] parity;
  int               limit;
  int               seed_ld [POINT_COUNT][4];
  int               hyp_ld  [POINT_COUNT][4];
  int               blk_cnt [POINT_COUNT];
  bit               on_stack [POINT_COUNT];
  bit               lvl_map [MAX_DEPTH][POINT_COUNT];
  logic [PT_W-1:0]  stack_pt [MAX_DEPTH];
  out_t             expected_results [$];

  function automatic logic [1:0] gf_dot(int m, logic [PT_W-1:0] x);
    logic [1:0] s;
    s = 0;
    for (int d = 0; d < DIMENSION; d++) s ^= gmul[m[2*d +: 2]][x[2*d +: 2]];
    return s;
  endfunction

  task automatic clear_all();
    logic [PT_W-1:0] col;
    for (int m = 0; m < POINT_COUNT; m++) begin
      for (int a = 0; a < 4; a++) begin
        seed_ld[m][a] = 0;
        hyp_ld[m][a]  = 0;
      end
      blk_cnt[m]  = 0;
      on_stack[m] = 0;
    end
    depth = 0;
    // unit vectors, then the parity columns
    for (int j = 0; j < SEED_COLUMNS; j++) begin
      col = '0;
      if (j < DIMENSION) col[2*j] = 1'b1;
      else if (j - DIMENSION < 4)
        for (int i = 0; i < DIMENSION; i++)
          col[2*i +: 2] = parity[2*(4*i + j - DIMENSION) +: 2];
      for (int m = 1; m < POINT_COUNT; m++) seed_ld[m][gf_dot(m, col)]++;
    end
  endtask

  task automatic try_place(logic [PT_W-1:0] c, output logic [1:0] st, output int nblk);
    int full_dirs [$];
    logic [1:0] a;
    logic [PT_W-1:0] d;
    nblk = 0;
    st = ST_REJECT;
    if (on_stack[c]) return;
    for (int m = 1; m < POINT_COUNT; m++) begin
      a = gf_dot(m, c);
      if (hyp_ld[m][a] + 1 + seed_ld[m][a] > limit) return;
    end
    for (int m = 1; m < POINT_COUNT; m++) begin
      a = gf_dot(m, c);
      hyp_ld[m][a]++;
      if (hyp_ld[m][a] + seed_ld[m][a] == limit) full_dirs = {full_dirs, m};
    end
    // q shares a full hyperplane with c exactly when m.(q^c) == 0
    for (int q = 0; q < POINT_COUNT; q++) begin
      lvl_map[depth][q] = 0;
      if (q == c || on_stack[q]) continue;
      d = q[PT_W-1:0] ^ c;
      foreach (full_dirs[i]) begin
        if (gf_dot(full_dirs[i], d) == 0) begin
          lvl_map[depth][q] = 1;
          blk_cnt[q]++;
          nblk++;
          break;
        end
      end
    end
    on_stack[c] = 1;
    stack_pt[depth] = c;
    depth++;
    st = ST_DONE;
  endtask

  task automatic pop_place();
    logic [PT_W-1:0] c;
    logic [1:0] a;
    depth--;
    c = stack_pt[depth];
    for (int q = 0; q < POINT_COUNT; q++)
      if (lvl_map[depth][q] && blk_cnt[q] > 0) blk_cnt[q]--;
    for (int m = 1; m < POINT_COUNT; m++) begin
      a = gf_dot(m, c);
      if (hyp_ld[m][a] > 0) hyp_ld[m][a]--;
    end
    on_stack[c] = 0;
  endtask

  task automatic predict(in_t it);
    out_t r;
    logic [1:0] st;
    int nb;
    r = '0;
    nb = 0;
    case (it.kind)
      KIND_CLEAR: clear_all();
      KIND_PLACE: begin
        if (depth >= MAX_DEPTH) r.status = ST_FULL;
        else begin
          try_place(it.point, st, nb);
          r.status = st;
        end
      end
      KIND_UNDO: begin
        if (depth == 0) r.status = ST_EMPTY;
        else pop_place();
      end
      default: r.point_free = !on_stack[it.point] && blk_cnt[it.point] == 0;
    endcase
    r.newly_blocked = PT_W'(nb);
    r.depth_now = DEPTH_W'(depth);
    expected_results = {expected_results, r};
  endtask

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      parity = '0;
      limit = int'(LIMIT_RESET);
      errors = 0;
      expected_results.delete();
      clear_all();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: %p", $time, result);
        end else begin
          e = expected_results.pop_front();
          if (e.status !== result.status || e.point_free !== result.point_free ||
              e.newly_blocked !== result.newly_blocked || e.depth_now !== result.depth_now) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
          end
        end
      end
      if (item_valid && !item_stall) predict(item);
      if (cfg_wen) begin
        if (cfg_index == REG_SEED_PARITY) parity = cfg_data;
        else limit = int'(cfg_data[LOAD_W-1:0]);
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/gf4_hyperplane_load_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf4_hyperplane_load_tracker_tb
// Drives clear, place, undo and query items through several parity and limit
// settings with random idle bursts on both channels; the checker predicts.
// ----------------------------------------------------------------------------
module gf4_hyperplane_load_tracker_tb;
  import glt_pkg::*;

  logic              clk = 0;
  logic              rst = 1;
  logic              item_valid = 0;
  logic              item_stall;
  in_t               item = '0;
  logic              result_valid;
  logic              result_stall = 0;
  out_t              result;
  logic              cfg_wen = 0;
  logic              cfg_index = REG_SEED_PARITY;
  logic [CFG_W-1:0]  cfg_data = '0;
  int                errors, pending, depth;
  bit                quiet = 0;
  int                stall_left = 0;
  logic [PT_W-1:0]   recent [$];

  always #4 clk = ~clk;

  gf4_hyperplane_load_tracker dut (.*);
  gf4_hyperplane_load_tracker_chk chk (.*);

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      result_stall <= 1;
    end else result_stall <= 0;
  end

  task automatic send(logic [1:0] k, logic [PT_W-1:0] p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1;
    item <= '{kind: k, point: p};
    // stall is registered: its level at the falling edge decides the next edge
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    if (k == KIND_PLACE) recent = {recent, p};
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] d);
    drain();
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  task automatic random_items(int n);
    int r;
    logic [PT_W-1:0] p;
    repeat (n) begin
      r = $urandom_range(0, 99);
      p = PT_W'($urandom_range(0, POINT_COUNT - 1));
      if (r < 4) send(KIND_CLEAR, p);
      else if (r < 62) send(KIND_PLACE, p);
      else if (r < 77) send(KIND_UNDO, p);
      else if (recent.size() > 0 && r < 90)
        send(KIND_QUERY, recent[$urandom_range(0, recent.size() - 1)]);
      else send(KIND_QUERY, p);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    // reset settings: empty stack, heavy seed loads
    send(KIND_UNDO, '0);
    send(KIND_QUERY, '0);
    send(KIND_PLACE, '0);
    send(KIND_PLACE, 10'h3ff);
    send(KIND_QUERY, 10'h3ff);
    write_reg(REG_LOAD_LIMIT, CFG_W'(15));
    write_reg(REG_SEED_PARITY, CFG_W'({$urandom, $urandom}));
    send(KIND_CLEAR, 10'h155);
    send(KIND_PLACE, 10'h3ff);
    send(KIND_PLACE, 10'h3ff);
    send(KIND_PLACE, 10'h000);
    send(KIND_QUERY, 10'h2aa);
    send(KIND_UNDO, '0);
    send(KIND_QUERY, 10'h000);
    // fill the stack, then one more place
    for (int t = 0; t < 60; t++) begin
      drain();
      if (depth >= MAX_DEPTH) break;
      send(KIND_PLACE, PT_W'($urandom_range(0, POINT_COUNT - 1)));
    end
    send(KIND_PLACE, PT_W'($urandom_range(0, POINT_COUNT - 1)));
    send(KIND_QUERY, 10'h0ff);
    // zero limit rejects every place
    write_reg(REG_LOAD_LIMIT, '0);
    send(KIND_CLEAR, '0);
    random_items(8);
    write_reg(REG_SEED_PARITY, {CFG_W{1'b1}});
    write_reg(REG_LOAD_LIMIT, CFG_W'(12));
    send(KIND_CLEAR, '0);
    random_items(30);
    // new parity without a clear keeps the old seeds
    write_reg(REG_SEED_PARITY, CFG_W'({$urandom, $urandom}));
    write_reg(REG_LOAD_LIMIT, CFG_W'(10 + $urandom_range(0, 5)));
    random_items(30);
    write_reg(REG_LOAD_LIMIT, CFG_W'(15));
    send(KIND_CLEAR, '0);
    random_items(25);
    quiet = 1;
    random_items(20);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS gf4_hyperplane_load_tracker");
    else $display("FAIL gf4_hyperplane_load_tracker");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("FAIL gf4_hyperplane_load_tracker");
    $finish;
  end

endmodule
